// ----- sv/itp_pkg.sv -----
// Shared types, character codes and precedence lookup for the infix-to-postfix converter.
// No dependencies; imported by the front end, the back end, the core and the bench.
`default_nettype none

package itp_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    typedef enum logic [1:0] {
        KIND_LETTER,
        KIND_LPAREN,
        KIND_RPAREN,
        KIND_OPER
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_OVERFLOW,
        ERR_UNMATCHED
    } err_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RPOP,
        S_OPPOP,
        S_FETCH,
        S_FLUSH,
        S_FINISH
    } state_t;

    // classified character handed from front end to back end
    typedef struct packed {
        logic [7:0] sym;
        logic       last;
        kind_t      kind;
        logic [1:0] prec;
    } item_t;

    function automatic logic [1:0] itp_prec(input logic [7:0] ch);
        logic [1:0] p;
        case (ch)
            CH_PLUS, CH_MINUS: p = 2'd1;
            CH_STAR, CH_SLASH: p = 2'd2;
            CH_DOLLAR:         p = 2'd3;
            default:           p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- sv/itp_front.sv -----
// Front end: accepts input characters, classifies them and queues them for the back end.
// Depends on itp_pkg.
`default_nettype none

module itp_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // [7:0] symbol
    input  wire logic          s_tlast,   // end_of_expr
    output itp_pkg::item_t     q_item,
    output logic               q_valid,
    input  wire logic          q_ready
);
    import itp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    function automatic kind_t classify(input logic [7:0] ch);
        kind_t k;
        if ((ch >= CH_UPPER_A && ch <= CH_UPPER_Z) || (ch >= CH_LOWER_A && ch <= CH_LOWER_Z)) begin
            k = KIND_LETTER;
        end else if (ch == CH_LPAREN) begin
            k = KIND_LPAREN;
        end else if (ch == CH_RPAREN) begin
            k = KIND_RPAREN;
        end else begin
            k = KIND_OPER;
        end
        return k;
    endfunction

    item_t             q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    item_t             in_item;
    logic              push, pop;

    assign in_item.sym  = s_tdata;
    assign in_item.last = s_tlast;
    assign in_item.kind = classify(s_tdata);
    assign in_item.prec = itp_prec(s_tdata);

    assign s_tready = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = q_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ----- sv/itp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                      aclk,
    input  wire logic                      we,
    input  wire logic [$clog2(DEPTH)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]          wdata,
    input  wire logic [$clog2(DEPTH)-1:0]  raddr,
    output logic      [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/itp_back.sv -----
// Back end: operator stack sequencer, result hold register and output register.
// Depends on itp_pkg and itp_ram.
`default_nettype none

module itp_back #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire itp_pkg::item_t q_item,
    input  wire logic           q_valid,
    output logic                q_ready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [15:0]         m_tdata,   // [7:0] out_symbol, [9:8] error_code, rest zero
    output logic                m_tuser,   // out_valid
    output logic                m_tlast    // done_res
);
    import itp_pkg::*;

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    state_t            state_reg, state_next;
    state_t            ret_reg, ret_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [7:0]        top_reg, top_next;
    logic [7:0]        cur_sym_reg, cur_sym_next;
    logic              cur_last_reg, cur_last_next;
    logic [1:0]        cur_prec_reg, cur_prec_next;

    // hold register: last result of the item stays here until its done flag is known
    logic              pend_v_reg, pend_v_next;
    logic [7:0]        pend_sym_reg, pend_sym_next;
    logic              pend_uv_reg, pend_uv_next;
    err_t              pend_err_reg, pend_err_next;

    logic              m_valid_reg, m_valid_next;
    logic [7:0]        out_sym_reg, out_sym_next;
    logic              out_uv_reg, out_uv_next;
    logic              out_done_reg, out_done_next;
    err_t              out_err_reg, out_err_next;

    logic              out_free, emit_ok;
    logic              emit, emit_uv;
    logic [7:0]        emit_sym;
    err_t              emit_err;
    logic              push_req;
    logic [7:0]        push_sym;
    state_t            push_ret;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_rdata;

    assign out_free  = !m_valid_reg || m_tready;
    assign emit_ok   = !pend_v_reg || out_free;
    // always points at the entry below the top, so a pop can reload the top next cycle
    assign ram_raddr = ADDR_W'(count_reg - CNT_W'(2));
    assign ram_waddr = count_reg[ADDR_W-1:0];

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, out_err_reg, out_sym_reg};
    assign m_tuser  = out_uv_reg;
    assign m_tlast  = out_done_reg;

    itp_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (push_sym),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        count_next    = count_reg;
        top_next      = top_reg;
        cur_sym_next  = cur_sym_reg;
        cur_last_next = cur_last_reg;
        cur_prec_next = cur_prec_reg;
        pend_v_next   = pend_v_reg;
        pend_sym_next = pend_sym_reg;
        pend_uv_next  = pend_uv_reg;
        pend_err_next = pend_err_reg;
        m_valid_next  = m_valid_reg;
        out_sym_next  = out_sym_reg;
        out_uv_next   = out_uv_reg;
        out_done_next = out_done_reg;
        out_err_next  = out_err_reg;
        q_ready       = 1'b0;
        emit          = 1'b0;
        emit_sym      = '0;
        emit_uv       = 1'b0;
        emit_err      = ERR_NONE;
        push_req      = 1'b0;
        push_sym      = '0;
        push_ret      = S_FINISH;
        ram_we        = 1'b0;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (q_valid && emit_ok) begin
                    q_ready       = 1'b1;
                    cur_sym_next  = q_item.sym;
                    cur_last_next = q_item.last;
                    cur_prec_next = q_item.prec;
                    case (q_item.kind)
                        KIND_LETTER: begin
                            emit       = 1'b1;
                            emit_sym   = q_item.sym;
                            emit_uv    = 1'b1;
                            state_next = q_item.last ? S_FLUSH : S_FINISH;
                        end
                        KIND_LPAREN: begin
                            push_req = 1'b1;
                            push_sym = q_item.sym;
                            push_ret = q_item.last ? S_FLUSH : S_FINISH;
                        end
                        KIND_RPAREN: state_next = S_RPOP;
                        default:     state_next = S_OPPOP;
                    endcase
                end
            end
            S_RPOP: begin
                if (count_reg == '0) begin
                    if (emit_ok) begin
                        emit       = 1'b1;
                        emit_err   = ERR_UNMATCHED;
                        state_next = cur_last_reg ? S_FLUSH : S_FINISH;
                    end
                end else if (top_reg == CH_LPAREN) begin
                    count_next = count_reg - 1'b1;
                    ret_next   = cur_last_reg ? S_FLUSH : S_FINISH;
                    state_next = S_FETCH;
                end else if (emit_ok) begin
                    emit       = 1'b1;
                    emit_sym   = top_reg;
                    emit_uv    = 1'b1;
                    count_next = count_reg - 1'b1;
                    ret_next   = S_RPOP;
                    state_next = S_FETCH;
                end
            end
            S_OPPOP: begin
                if (emit_ok) begin
                    if (count_reg != '0 && itp_prec(top_reg) > cur_prec_reg) begin
                        emit       = 1'b1;
                        emit_sym   = top_reg;
                        emit_uv    = 1'b1;
                        count_next = count_reg - 1'b1;
                        ret_next   = S_OPPOP;
                        state_next = S_FETCH;
                    end else begin
                        push_req = 1'b1;
                        push_sym = cur_sym_reg;
                        push_ret = cur_last_reg ? S_FLUSH : S_FINISH;
                    end
                end
            end
            S_FETCH: begin
                top_next   = ram_rdata;
                state_next = ret_reg;
            end
            S_FLUSH: begin
                if (count_reg == '0) begin
                    state_next = S_FINISH;
                end else if (emit_ok) begin
                    emit       = 1'b1;
                    emit_sym   = top_reg;
                    emit_uv    = 1'b1;
                    count_next = count_reg - 1'b1;
                    ret_next   = S_FLUSH;
                    state_next = S_FETCH;
                end
            end
            S_FINISH: begin
                if (pend_v_reg) begin
                    if (out_free) begin
                        m_valid_next  = 1'b1;
                        out_sym_next  = pend_sym_reg;
                        out_uv_next   = pend_uv_reg;
                        out_err_next  = pend_err_reg;
                        out_done_next = cur_last_reg;
                        pend_v_next   = 1'b0;
                        state_next    = S_IDLE;
                    end
                end else if (cur_last_reg) begin
                    // item released nothing: bare status result carries the done flag
                    if (out_free) begin
                        m_valid_next  = 1'b1;
                        out_sym_next  = '0;
                        out_uv_next   = 1'b0;
                        out_err_next  = ERR_NONE;
                        out_done_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                end else begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (push_req) begin
            state_next = push_ret;
            if (count_reg >= CNT_W'(STACK_DEPTH)) begin
                count_next = '0;
                emit       = 1'b1;
                emit_err   = ERR_OVERFLOW;
            end else begin
                ram_we     = 1'b1;
                top_next   = push_sym;
                count_next = count_reg + 1'b1;
            end
        end

        if (emit) begin
            if (pend_v_reg) begin
                m_valid_next  = 1'b1;
                out_sym_next  = pend_sym_reg;
                out_uv_next   = pend_uv_reg;
                out_err_next  = pend_err_reg;
                out_done_next = 1'b0;
            end
            pend_v_next   = 1'b1;
            pend_sym_next = emit_sym;
            pend_uv_next  = emit_uv;
            pend_err_next = emit_err;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_FINISH;
            count_reg   <= '0;
            pend_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            count_reg   <= count_next;
            pend_v_reg  <= pend_v_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg      <= top_next;
        cur_sym_reg  <= cur_sym_next;
        cur_last_reg <= cur_last_next;
        cur_prec_reg <= cur_prec_next;
        pend_sym_reg <= pend_sym_next;
        pend_uv_reg  <= pend_uv_next;
        pend_err_reg <= pend_err_next;
        out_sym_reg  <= out_sym_next;
        out_uv_reg   <= out_uv_next;
        out_done_reg <= out_done_next;
        out_err_reg  <= out_err_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_fetch_after_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FETCH |->
            ($past(state_reg) == S_RPOP || $past(state_reg) == S_OPPOP ||
             $past(state_reg) == S_FLUSH))
        else $error("top reload without a pop");

    a_unmatched_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RPOP && count_reg == '0 && emit_ok) |=>
            (pend_v_reg && pend_err_reg == ERR_UNMATCHED && !pend_uv_reg))
        else $error("unmatched close paren not reported");

    a_last_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH && cur_last_reg) |-> count_reg == '0)
        else $error("stack not empty at end of expression");

endmodule

`default_nettype wire

// ----- sv/infix_to_postfix_converter_core.sv -----
// Infix-to-postfix converter: front end queue, stack back end and output register.
// Depends on itp_pkg, itp_front, itp_back (which holds the itp_ram stack).
// Path: a letter goes from the front queue through the hold register (dispatch) to the output register (close).
// Handling: the back end takes a new character only from its idle state, once done with the last; each operator
// popped costs an emit step and a top reload from the registered RAM, and a last character adds a flush.
// Reset: aresetn synchronous active low empties the queue, stack and output; no clearing pass.
`default_nettype none

module infix_to_postfix_converter_core #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] symbol
    input  wire logic        s_tlast,   // end_of_expr
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_symbol, [9:8] error_code, rest zero
    output logic             m_tuser,   // out_valid
    output logic             m_tlast    // done_res
);
    import itp_pkg::*;

    item_t q_item;
    logic  q_valid;
    logic  q_ready;

    itp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready)
    );

    itp_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ----- bench/infix_to_postfix_converter_core_tb.sv -----
// Self-checking bench for infix_to_postfix_converter_core: drives expression characters on the
// input stream and checks every postfix transaction against an operator-stack predictor.
// Depends on itp_pkg and the converter RTL.
`default_nettype none

module infix_to_postfix_converter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import itp_pkg::*;

    localparam int DEPTH        = STACK_DEPTH_DEF;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int SETTLE       = 16;

    typedef struct packed {
        logic [7:0] sym;
        logic       valid;
        logic       done;
        err_t       err;
    } postfix_sym_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // predictor state
    logic [7:0]   op_stack [DEPTH];
    int           op_depth = 0;
    int           released;
    postfix_sym_t pending_postfix [$];

    logic [7:0] expr_buf [$];
    int  mismatches = 0;
    int  cycles = 0;
    int  hold_cycles = 0;
    int  stall_left = 0;
    bit  quiet = 1'b0;
    bit  receiver_on = 1'b0;

    logic [7:0] arith_ops [5] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_DOLLAR};

    infix_to_postfix_converter_core #(.STACK_DEPTH(DEPTH)) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] symbol
        .s_tlast  (s_tlast),   // end_of_expr
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [7:0] out_symbol, [9:8] error_code, rest zero
        .m_tuser  (m_tuser),   // out_valid
        .m_tlast  (m_tlast)    // done_res
    );

    always #2 aclk = ~aclk;

    // ---------------------------------------------------------------- predictor

    function automatic int op_rank(input logic [7:0] c);
        if (c == CH_PLUS || c == CH_MINUS) return 1;
        if (c == CH_STAR || c == CH_SLASH) return 2;
        if (c == CH_DOLLAR) return 3;
        return 0;
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    function automatic void emit_postfix(input logic [7:0] sym, input logic valid,
                                         input err_t err);
        postfix_sym_t r;
        r.sym   = sym;
        r.valid = valid;
        r.done  = 1'b0;
        r.err   = err;
        pending_postfix.push_back(r);
        released++;
    endfunction

    function automatic void push_operator(input logic [7:0] c);
        if (op_depth >= DEPTH) begin
            op_depth = 0;
            emit_postfix(8'h00, 1'b0, ERR_OVERFLOW);
        end else begin
            op_stack[op_depth] = c;
            op_depth++;
        end
    endfunction

    function automatic void convert_symbol(input logic [7:0] c, input logic last);
        bit found;
        int p;
        released = 0;
        if (is_letter(c)) begin
            emit_postfix(c, 1'b1, ERR_NONE);
        end else if (c == CH_LPAREN) begin
            push_operator(c);
        end else if (c == CH_RPAREN) begin
            found = 1'b0;
            while (op_depth > 0 && !found) begin
                op_depth--;
                if (op_stack[op_depth] == CH_LPAREN)
                    found = 1'b1;
                else
                    emit_postfix(op_stack[op_depth], 1'b1, ERR_NONE);
            end
            if (!found)
                emit_postfix(8'h00, 1'b0, ERR_UNMATCHED);
        end else begin
            p = op_rank(c);
            while (op_depth > 0 && op_rank(op_stack[op_depth - 1]) > p) begin
                op_depth--;
                emit_postfix(op_stack[op_depth], 1'b1, ERR_NONE);
            end
            push_operator(c);
        end
        if (last) begin
            while (op_depth > 0) begin
                op_depth--;
                emit_postfix(op_stack[op_depth], 1'b1, ERR_NONE);
            end
            // end of expression always yields at least a bare status transaction
            if (released == 0)
                emit_postfix(8'h00, 1'b0, ERR_NONE);
            pending_postfix[pending_postfix.size() - 1].done = 1'b1;
        end
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_symbol(input logic [7:0] c, input logic last);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        convert_symbol(c, last);
    endtask

    task automatic send_expr();
        for (int i = 0; i < expr_buf.size(); i++)
            send_symbol(expr_buf[i], i == expr_buf.size() - 1);
        expr_buf.delete();
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            expr_buf.push_back(s[i]);
        send_expr();
    endtask

    // sender stops and waits for every outstanding result
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_postfix.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // receiver: random stall bursts, plus a long hold-off on request
    initial begin
        wait (receiver_on);
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left = stall_left - 1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 7);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- checker

    always @(posedge aclk) begin
        postfix_sym_t exp_r;
        logic [15:0]  exp_data;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_postfix.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: unexpected transaction data=%h user=%b last=%b",
                             $realtime, m_tdata, m_tuser, m_tlast);
                mismatches++;
            end else begin
                exp_r    = pending_postfix.pop_front();
                exp_data = {6'b0, exp_r.err, exp_r.sym};
                if (m_tdata !== exp_data || m_tuser !== exp_r.valid
                        || m_tlast !== exp_r.done) begin
                    if (mismatches < 10)
                        $display("%0t: mismatch exp data=%h user=%b last=%b, got %h %b %b",
                                 $realtime, exp_data, exp_r.valid, exp_r.done,
                                 m_tdata, m_tuser, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("infix_to_postfix_converter_core_tb: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus

    task automatic push_letter();
        if ($urandom_range(0, 1) != 0)
            expr_buf.push_back(8'(CH_UPPER_A + $urandom_range(0, 25)));
        else
            expr_buf.push_back(8'(CH_LOWER_A + $urandom_range(0, 25)));
    endtask

    task automatic push_op();
        if ($urandom_range(0, 9) == 0)
            expr_buf.push_back(8'($urandom_range(0, 255)));
        else
            expr_buf.push_back(arith_ops[$urandom_range(0, 4)]);
    endtask

    task automatic gen_operand(input int level);
        if (level < 4 && expr_buf.size() < 30 && $urandom_range(0, 3) == 0) begin
            expr_buf.push_back(CH_LPAREN);
            gen_expr(level + 1);
            expr_buf.push_back(CH_RPAREN);
        end else begin
            push_letter();
        end
    endtask

    task automatic gen_expr(input int level);
        int terms;
        terms = $urandom_range(1, 4);
        gen_operand(level);
        repeat (terms - 1) begin
            push_op();
            gen_operand(level);
        end
    endtask

    // letter boundaries; neighbors of the letter ranges act as rank-0 operators
    task automatic test_letter_bounds();
        send_string("A@Z[a`z{");
        drain();
    endtask

    task automatic test_operator_ranks();
        send_string("a+b*c$d/e-f");
        drain();
    endtask

    task automatic test_parens();
        send_string("(a+b)*(c");   // unclosed '(' gets flushed
        send_string(")");          // unmatched, error carries done
        send_string("()");         // nothing released: bare done
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hFF, 1'b1);
        drain();
    endtask

    task automatic test_overflow();
        repeat (DEPTH) expr_buf.push_back(CH_LPAREN);
        expr_buf.push_back(CH_LPAREN);
        send_expr();
        drain();
    endtask

    // receiver holds off while the sender keeps offering; input must stall
    task automatic test_backpressure();
        hold_cycles = 200;
        send_string("a+b*c-d/e$f*(g+h)-i$j");
        drain();
    endtask

    task automatic test_random_exprs();
        int sent;
        int pick;
        int idx;
        sent = 0;
        while (sent < 230) begin
            pick  = $urandom_range(0, 99);
            quiet = ($urandom_range(0, 4) == 0);
            if (pick < 75) begin
                gen_expr(0);
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 10))
                    expr_buf.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 94) begin
                gen_expr(0);
                idx = $urandom_range(0, expr_buf.size() - 1);
                expr_buf.insert(idx, ($urandom_range(0, 1) != 0) ? CH_RPAREN : CH_LPAREN);
            end else begin
                gen_expr(0);
                repeat ($urandom_range(DEPTH - 4, DEPTH + 4))
                    expr_buf.push_front(CH_LPAREN);
            end
            sent += expr_buf.size();
            send_expr();
        end
        drain();
    endtask

    task automatic test_steady_stream();
        int sent;
        quiet = 1'b1;
        sent  = 0;
        while (sent < 30) begin
            gen_expr(0);
            sent += expr_buf.size();
            send_expr();
        end
        drain();
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        receiver_on = 1'b1;
        test_letter_bounds();
        test_operator_ranks();
        test_parens();
        test_overflow();
        test_backpressure();
        test_random_exprs();
        test_steady_stream();
        if (mismatches == 0 && pending_postfix.size() == 0)
            $display("infix_to_postfix_converter_core_tb: PASS");
        else
            $display("infix_to_postfix_converter_core_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
sv/itp_pkg.sv
sv/itp_front.sv
sv/itp_ram.sv
sv/itp_back.sv
sv/infix_to_postfix_converter_core.sv
bench/infix_to_postfix_converter_core_tb.sv
